>>> sv/ihex_pkg.sv
// ihex_pkg: request and result types, parser state record and character constants
// shared by the step logic and the top level of the hex record loader
// no dependencies
package ihex_pkg;

	localparam int unsigned POS_W  = 10;
	localparam int unsigned ADDR_W = 17;

	localparam logic [POS_W-1:0] POS_MAX    = 10'd1023;
	localparam logic [7:0]       CH_COLON   = 8'h3a;
	localparam logic [7:0]       CH_NEWLINE = 8'd10;
	localparam logic [7:0]       REC_DATA   = 8'h00;
	localparam logic [7:0]       REC_EOF    = 8'h01;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_of_image;
	} char_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] write_address;
		logic [7:0]        write_value;
	} rec_t;

	typedef struct packed {
		logic [POS_W-1:0] line_position;
		logic             line_accepted;
		logic [7:0]       record_length;
		logic [15:0]      load_address;
		logic [7:0]       record_kind;
		logic [3:0]       high_nibble;
		logic             image_finished;
	} state_t;

	localparam state_t STATE_RESET = '0;

	// non-hex characters read as zero
	function automatic logic [3:0] hex_digit(input logic [7:0] ch);
		logic [3:0] d;
		d = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			d = 4'(ch - 8'h30);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			d = 4'(ch - 8'h41 + 8'd10);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			d = 4'(ch - 8'h61 + 8'd10);
		end
		return d;
	endfunction

endpackage

>>> sv/ihex_step.sv
// ihex_step: next parser state and optional result for one character
// depends on ihex_pkg
module ihex_step (
	input  ihex_pkg::state_t st,
	input  ihex_pkg::char_t  ch,
	output ihex_pkg::state_t nxt,
	output logic             res_valid,
	output ihex_pkg::rec_t   res
);

	logic [3:0]                  digit;
	logic [7:0]                  pair;
	logic [ihex_pkg::POS_W-1:0]  pos;
	logic [ihex_pkg::POS_W-1:0]  data_off;
	logic [8:0]                  idx;

	assign digit    = ihex_pkg::hex_digit(ch.text_char);
	assign pair     = {st.high_nibble, digit};
	assign pos      = st.line_position;
	assign data_off = pos - ihex_pkg::POS_W'(10);
	assign idx      = data_off[ihex_pkg::POS_W-1:1];

	always_comb begin
		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		if (!st.image_finished) begin
			if (ch.text_char == ihex_pkg::CH_NEWLINE) begin
				nxt.line_position = '0;
				nxt.line_accepted = 1'b0;
			end else begin
				if (pos == '0) begin
					nxt.line_accepted = (ch.text_char == ihex_pkg::CH_COLON);
				end else if (st.line_accepted && pos < ihex_pkg::POS_MAX) begin
					if (pos[0]) begin
						nxt.high_nibble = digit;
					end else begin
						case (pos)
							ihex_pkg::POS_W'(2): nxt.record_length = pair;
							ihex_pkg::POS_W'(4): nxt.load_address[15:8] = pair;
							ihex_pkg::POS_W'(6): nxt.load_address[7:0] = pair;
							ihex_pkg::POS_W'(8): begin
								nxt.record_kind = pair;
								if (pair == ihex_pkg::REC_EOF) begin
									res_valid          = 1'b1;
									res.kind           = ihex_pkg::KIND_END;
									nxt.image_finished = 1'b1;
								end
							end
							default: begin
								// data pair, index counted from position ten
								if (st.record_kind == ihex_pkg::REC_DATA
										&& idx < {1'b0, st.record_length}) begin
									res_valid         = 1'b1;
									res.kind          = ihex_pkg::KIND_WRITE;
									res.write_address = ihex_pkg::ADDR_W'(st.load_address)
										+ ihex_pkg::ADDR_W'(idx);
									res.write_value   = pair;
								end
							end
						endcase
					end
				end
				if (pos < ihex_pkg::POS_MAX) begin
					nxt.line_position = pos + ihex_pkg::POS_W'(1);
				end
			end
		end
		if (ch.last_of_image) begin
			nxt = ihex_pkg::STATE_RESET;
		end
	end

endmodule

>>> sv/intel_hex_record_loader.sv
// intel_hex_record_loader: one character per cycle, result held in a register
// the parser state and the result register are both loaded at the request edge, so
// the result is valid the cycle after its character; throughput one character a cycle,
// limited only by the single result register draining through rec_ready
// arst_n clears the parser state and the result valid flag; payload registers are not reset
// depends on ihex_pkg and ihex_step
module intel_hex_record_loader (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_ready,
	input  ihex_pkg::char_t  char_req,
	output logic             rec_valid,
	input  logic             rec_ready,
	output ihex_pkg::rec_t   rec
);

	ihex_pkg::state_t st_q;
	ihex_pkg::state_t st_nxt;
	logic             res_valid;
	ihex_pkg::rec_t   res;
	logic             rec_valid_q;
	ihex_pkg::rec_t   rec_q;
	logic             take;

	ihex_step u_step (
		.st        (st_q),
		.ch        (char_req),
		.nxt       (st_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	assign char_ready = !rec_valid_q || rec_ready;
	assign take       = char_valid && char_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ihex_pkg::STATE_RESET;
			rec_valid_q <= 1'b0;
		end else begin
			if (take) begin
				st_q        <= st_nxt;
				rec_valid_q <= res_valid;
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			rec_q <= res;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

`ifndef SYNTHESIS
	// the final character of an image always returns the parser to its start state
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && char_req.last_of_image |=> st_q == ihex_pkg::STATE_RESET)
		else $error("parser not reset after last character");

	// once the end record is seen nothing else comes out until the image ends
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		take && st_q.image_finished |=> !rec_valid)
		else $error("result after end record");

	// an end result carries zero address and value
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec.kind == ihex_pkg::KIND_END |->
			rec.write_address == '0 && rec.write_value == '0)
		else $error("end result with nonzero fields");

	// a newline in an open image restarts the line
	a_newline: assert property (@(posedge clk) disable iff (!arst_n)
		take && !st_q.image_finished && char_req.text_char == ihex_pkg::CH_NEWLINE
			|=> st_q.line_position == '0 && !st_q.line_accepted)
		else $error("newline did not restart line");
`endif

endmodule
